// ===== sv/pccb_pkg.sv =====
`timescale 1ns / 1ps

package pccb_pkg;

   localparam int NUM_BACKENDS_DEF = 8;

   localparam logic [4:0]  BSIZE_RST    = 5'd5;
   localparam logic [4:0]  OCC_MAX      = 5'd31;
   localparam logic [23:0] SHOT_SUM_MAX = 24'hFFFFFF;
   localparam logic [9:0]  NS_PER_SHOT  = 10'd1000;

   // request action codes
   localparam logic ACT_INTAKE = 1'b0;
   localparam logic ACT_FLUSH  = 1'b1;

   // response status codes
   localparam logic ST_OK          = 1'b0;
   localparam logic ST_BAD_BACKEND = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic take_req;   // latch request word, start table read
      logic rd_scan;    // read table at scan index
      logic int_calc;   // intake update, load result fields
      logic fl_calc;    // residual commit of scanned pool
      logic fl_empty;   // empty flush result
      logic mul;        // ETA product into result
      logic idx_step;   // advance scan index
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic new_flush;  // action of the word on the request port
      logic scan_hit;   // pool at scan index is non-empty
      logic scan_none;  // no non-empty pool at or above scan index
      logic rsp_last;   // pending result is the final one
   } sts_type;

endpackage

// ===== sv/pccb_ctrl.sv =====
`timescale 1ns / 1ps

module pccb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pccb_pkg::sts_type  sts,
   output pccb_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INT     = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_FL_CALC = 6'b001000,
      ST_MUL     = 6'b010000,
      ST_HOLD    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = sts.new_flush ? ST_SCAN : ST_INT;
            end
         end
         ST_INT: begin
            cmd.int_calc = 1'b1;
            state_in     = ST_MUL;
         end
         ST_SCAN: begin
            priority if (sts.scan_hit) begin
               cmd.rd_scan = 1'b1;
               state_in    = ST_FL_CALC;
            end else if (sts.scan_none) begin
               cmd.fl_empty = 1'b1;
               state_in     = ST_MUL;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         ST_FL_CALC: begin
            cmd.fl_calc = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               if (sts.rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/pccb_dpath.sv =====
`timescale 1ns / 1ps

module pccb_dpath #(
   parameter int NUM_BACKENDS = pccb_pkg::NUM_BACKENDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  pccb_pkg::cmd_type  cmd,
   output pccb_pkg::sts_type  sts,
   input  logic               csr_we,
   input  logic [4:0]         csr_wdata,
   input  logic               req_action,
   input  logic [7:0]         req_backend,
   input  logic [31:0]        req_job_id,
   input  logic [7:0]         req_fragment,
   input  logic [19:0]        req_shots,
   output logic               rsp_status,
   output logic               rsp_committed,
   output logic               rsp_residual,
   output logic [7:0]         rsp_out_backend,
   output logic [31:0]        rsp_cluster_number,
   output logic [23:0]        rsp_shot_total,
   output logic [31:0]        rsp_head_id,
   output logic [7:0]         rsp_head_fragment,
   output logic [33:0]        rsp_eta_add_ns,
   output logic [4:0]         rsp_pool_count,
   output logic [6:0]         rsp_flushed_count,
   output logic               rsp_last
);

   localparam int         IDX_W = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;
   localparam logic [7:0] NB_B  = 8'(NUM_BACKENDS);

   typedef struct packed {
      logic [4:0]  occ;
      logic [23:0] sum;
      logic [31:0] hid;
      logic [7:0]  hfrag;
   } rec_type;

   // pool table
   rec_type                  mem [NUM_BACKENDS];
   rec_type                  rd_ff;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   rec_type                  wr_rec;

   logic [NUM_BACKENDS-1:0]  valid_ff, valid_in;
   logic [31:0]              cluster_ff, cluster_in;
   logic [4:0]               bsize_ff;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [6:0]               flushed_ff, flushed_in;

   // latched request word
   logic [7:0]               bk_ff;
   logic [31:0]              job_ff;
   logic [7:0]               frag_ff;
   logic [19:0]              shots_ff;

   // result fields
   logic                     status_ff, status_in;
   logic                     committed_ff, committed_in;
   logic                     residual_ff, residual_in;
   logic [7:0]               obk_ff, obk_in;
   logic [31:0]              cnum_ff, cnum_in;
   logic [23:0]              cshots_ff, cshots_in;
   logic [31:0]              hid_ff, hid_in;
   logic [7:0]               hfrag_ff, hfrag_in;
   logic [33:0]              eta_ff, eta_in;
   logic [4:0]               pcount_ff, pcount_in;
   logic [6:0]               fcount_ff, fcount_in;
   logic                     last_ff, last_in;

   // intake arithmetic
   logic                     in_range;
   logic [IDX_W-1:0]         bk_idx;
   rec_type                  cur;
   logic [4:0]               occ_new;
   logic [24:0]              sum_wide;
   logic [23:0]              sum_new;
   logic                     commit;
   logic [NUM_BACKENDS-1:0]  from_idx;

   assign in_range = (bk_ff < NB_B);
   assign bk_idx   = in_range ? bk_ff[IDX_W-1:0] : '0;
   assign from_idx = valid_ff >> idx_ff;

   always_comb begin
      sts.new_flush = (req_action == pccb_pkg::ACT_FLUSH);
      sts.scan_hit  = from_idx[0];
      sts.scan_none = ~|from_idx;
      sts.rsp_last  = last_ff;
   end

   always_comb begin
      cur = valid_ff[bk_idx] ? rd_ff : '0;
      occ_new  = (cur.occ < pccb_pkg::OCC_MAX) ? cur.occ + 5'd1 : pccb_pkg::OCC_MAX;
      sum_wide = {1'b0, cur.sum} + 25'(shots_ff);
      sum_new  = sum_wide[24] ? pccb_pkg::SHOT_SUM_MAX : sum_wide[23:0];
      commit   = (occ_new >= bsize_ff);
      wr_rec.occ   = occ_new;
      wr_rec.sum   = sum_new;
      wr_rec.hid   = (cur.occ == 5'd0) ? job_ff  : cur.hid;
      wr_rec.hfrag = (cur.occ == 5'd0) ? frag_ff : cur.hfrag;
   end

   assign rd_en   = (cmd.take_req && (req_backend < NB_B)) || cmd.rd_scan;
   assign rd_addr = cmd.rd_scan ? idx_ff : req_backend[IDX_W-1:0];
   assign wr_en   = cmd.int_calc && in_range && !commit;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[bk_idx] <= wr_rec;
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      cluster_in   = cluster_ff;
      idx_in       = idx_ff;
      flushed_in   = flushed_ff;
      status_in    = status_ff;
      committed_in = committed_ff;
      residual_in  = residual_ff;
      obk_in       = obk_ff;
      cnum_in      = cnum_ff;
      cshots_in    = cshots_ff;
      hid_in       = hid_ff;
      hfrag_in     = hfrag_ff;
      eta_in       = eta_ff;
      pcount_in    = pcount_ff;
      fcount_in    = fcount_ff;
      last_in      = last_ff;

      if (cmd.take_req) begin
         idx_in     = '0;
         flushed_in = '0;
      end
      if (cmd.idx_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.int_calc) begin
         status_in    = in_range ? pccb_pkg::ST_OK : pccb_pkg::ST_BAD_BACKEND;
         committed_in = in_range && commit;
         residual_in  = 1'b0;
         obk_in       = bk_ff;
         cnum_in      = '0;
         cshots_in    = '0;
         hid_in       = '0;
         hfrag_in     = '0;
         pcount_in    = '0;
         fcount_in    = '0;
         last_in      = 1'b1;
         if (in_range) begin
            if (commit) begin
               valid_in[bk_idx] = 1'b0;
               cluster_in       = cluster_ff + 32'd1;
               cnum_in          = cluster_ff + 32'd1;
               cshots_in        = sum_new;
               hid_in           = wr_rec.hid;
               hfrag_in         = wr_rec.hfrag;
            end else begin
               valid_in[bk_idx] = 1'b1;
               pcount_in        = occ_new;
            end
         end
      end

      if (cmd.fl_calc) begin
         valid_in[idx_ff] = 1'b0;
         cluster_in       = cluster_ff + 32'd1;
         flushed_in       = flushed_ff + 7'd1;
         status_in        = pccb_pkg::ST_OK;
         committed_in     = 1'b1;
         residual_in      = 1'b1;
         obk_in           = 8'(idx_ff);
         cnum_in          = cluster_ff + 32'd1;
         cshots_in        = rd_ff.sum;
         hid_in           = rd_ff.hid;
         hfrag_in         = '0;
         pcount_in        = '0;
         // final result when nothing non-empty lies above this pool
         last_in          = ~|(from_idx >> 1);
         fcount_in        = last_in ? flushed_ff + 7'd1 : 7'd0;
      end

      if (cmd.fl_empty) begin
         status_in    = pccb_pkg::ST_OK;
         committed_in = 1'b0;
         residual_in  = 1'b0;
         obk_in       = '0;
         cnum_in      = '0;
         cshots_in    = '0;
         hid_in       = '0;
         hfrag_in     = '0;
         pcount_in    = '0;
         fcount_in    = '0;
         last_in      = 1'b1;
      end

      if (cmd.mul) begin
         eta_in = 34'(cshots_ff) * 34'(pccb_pkg::NS_PER_SHOT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         cluster_ff <= '0;
         bsize_ff   <= pccb_pkg::BSIZE_RST;
         idx_ff     <= '0;
         flushed_ff <= '0;
         last_ff    <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         cluster_ff <= cluster_in;
         idx_ff     <= idx_in;
         flushed_ff <= flushed_in;
         last_ff    <= last_in;
         if (csr_we) begin
            bsize_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         bk_ff    <= req_backend;
         job_ff   <= req_job_id;
         frag_ff  <= req_fragment;
         shots_ff <= req_shots;
      end
      status_ff    <= status_in;
      committed_ff <= committed_in;
      residual_ff  <= residual_in;
      obk_ff       <= obk_in;
      cnum_ff      <= cnum_in;
      cshots_ff    <= cshots_in;
      hid_ff       <= hid_in;
      hfrag_ff     <= hfrag_in;
      eta_ff       <= eta_in;
      pcount_ff    <= pcount_in;
      fcount_ff    <= fcount_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_committed      = committed_ff;
   assign rsp_residual       = residual_ff;
   assign rsp_out_backend    = obk_ff;
   assign rsp_cluster_number = cnum_ff;
   assign rsp_shot_total     = cshots_ff;
   assign rsp_head_id        = hid_ff;
   assign rsp_head_fragment  = hfrag_ff;
   assign rsp_eta_add_ns     = eta_ff;
   assign rsp_pool_count     = pcount_ff;
   assign rsp_flushed_count  = fcount_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== sv/per_channel_count_bundler.sv =====
`timescale 1ns / 1ps
// Intake word: table read, update/write-back, ETA multiply and hand-off in turn;
//   no new word is taken until its result has been handed off.
// Flush word: steps past each empty backend and commits each occupied pool;
//   a flush of an all-empty table gives its one result, an empty one.
// Reset: synchronous, active high. Pools empty, cluster number 0, bundle size 5.
//   Pool occupancy is tracked by per-backend valid bits, so no clearing pass.

module per_channel_count_bundler #(
   parameter int NUM_BACKENDS = pccb_pkg::NUM_BACKENDS_DEF
) (
   input  logic         clock,
   input  logic         reset,

   // bundle size register
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata,

   // request channel
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_action,
   input  logic [7:0]   req_backend,
   input  logic [31:0]  req_job_id,
   input  logic [7:0]   req_fragment,
   input  logic [19:0]  req_shots,

   // response channel
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_status,
   output logic         rsp_committed,
   output logic         rsp_residual,
   output logic [7:0]   rsp_out_backend,
   output logic [31:0]  rsp_cluster_number,
   output logic [23:0]  rsp_shot_total,
   output logic [31:0]  rsp_head_id,
   output logic [7:0]   rsp_head_fragment,
   output logic [33:0]  rsp_eta_add_ns,
   output logic [4:0]   rsp_pool_count,
   output logic [6:0]   rsp_flushed_count,
   output logic         rsp_last
);

   // Controller sequences one word at a time; the datapath owns the pool
   // table (one read port, one write port, registered read), the valid
   // bits, the cluster number and the response register.
   pccb_pkg::cmd_type cmd;
   pccb_pkg::sts_type sts;

   pccb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Flush walks the backends by index; the final result is spotted by
   // looking for any occupied pool above the current one, so the scan
   // stops straight after the last commit.
   pccb_dpath #(
      .NUM_BACKENDS (NUM_BACKENDS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_action         (req_action),
      .req_backend        (req_backend),
      .req_job_id         (req_job_id),
      .req_fragment       (req_fragment),
      .req_shots          (req_shots),
      .rsp_status         (rsp_status),
      .rsp_committed      (rsp_committed),
      .rsp_residual       (rsp_residual),
      .rsp_out_backend    (rsp_out_backend),
      .rsp_cluster_number (rsp_cluster_number),
      .rsp_shot_total     (rsp_shot_total),
      .rsp_head_id        (rsp_head_id),
      .rsp_head_fragment  (rsp_head_fragment),
      .rsp_eta_add_ns     (rsp_eta_add_ns),
      .rsp_pool_count     (rsp_pool_count),
      .rsp_flushed_count  (rsp_flushed_count),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int NB          = pccb_pkg::NUM_BACKENDS_DEF;
   localparam int IDLE_PCT    = 12;
   localparam int WATCH_LIMIT = 1000;   // cycles with no handshake on either side
   localparam int HOLD_CYCLES = 150;    // long receiver hold-off
   localparam int HOLD_AT     = 40;     // start hold-off once this many results are in
   localparam int DRAIN_PAUSE = 8;      // margin for the turnaround back to idle

   localparam logic ACT_INTAKE     = pccb_pkg::ACT_INTAKE;
   localparam logic ACT_FLUSH      = pccb_pkg::ACT_FLUSH;
   localparam logic ST_OK          = pccb_pkg::ST_OK;
   localparam logic ST_BAD_BACKEND = pccb_pkg::ST_BAD_BACKEND;

   typedef struct packed {
      logic        action;
      logic [7:0]  backend;
      logic [31:0] job_id;
      logic [7:0]  fragment;
      logic [19:0] shots;
   } req_word_type;

   typedef struct packed {
      logic        status;
      logic        committed;
      logic        residual;
      logic [7:0]  out_backend;
      logic [31:0] cluster_number;
      logic [23:0] shot_total;
      logic [31:0] head_id;
      logic [7:0]  head_fragment;
      logic [33:0] eta_add_ns;
      logic [4:0]  pool_count;
      logic [6:0]  flushed_count;
      logic        last;
   } rsp_word_type;

   typedef struct {
      bit           wr_size;
      logic [4:0]   size;
      req_word_type w;
      bit           typed;
      rsp_word_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [4:0]  csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [7:0]  req_backend;
   logic [31:0] req_job_id;
   logic [7:0]  req_fragment;
   logic [19:0] req_shots;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_status;
   logic        rsp_committed;
   logic        rsp_residual;
   logic [7:0]  rsp_out_backend;
   logic [31:0] rsp_cluster_number;
   logic [23:0] rsp_shot_total;
   logic [31:0] rsp_head_id;
   logic [7:0]  rsp_head_fragment;
   logic [33:0] rsp_eta_add_ns;
   logic [4:0]  rsp_pool_count;
   logic [6:0]  rsp_flushed_count;
   logic        rsp_last;

   per_channel_count_bundler dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_backend        (req_backend),
      .req_job_id         (req_job_id),
      .req_fragment       (req_fragment),
      .req_shots          (req_shots),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_committed      (rsp_committed),
      .rsp_residual       (rsp_residual),
      .rsp_out_backend    (rsp_out_backend),
      .rsp_cluster_number (rsp_cluster_number),
      .rsp_shot_total     (rsp_shot_total),
      .rsp_head_id        (rsp_head_id),
      .rsp_head_fragment  (rsp_head_fragment),
      .rsp_eta_add_ns     (rsp_eta_add_ns),
      .rsp_pool_count     (rsp_pool_count),
      .rsp_flushed_count  (rsp_flushed_count),
      .rsp_last           (rsp_last)
   );

   // clock, 12 ns period
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Bundling table mirror
   // ---------------------------------------------------------------------
   logic [4:0]  pool_occ   [NB];
   logic [23:0] pool_shots [NB];
   logic [31:0] pool_id    [NB];
   logic [7:0]  pool_frag  [NB];
   logic [31:0] cluster_no;
   logic [4:0]  bundle_sz;

   rsp_word_type cluster_q [$];   // results still owed by the block
   int           mismatches;
   int           rsp_seen;
   int           rand_items;
   dir_row_type  dir_tab [$];

   task automatic table_clear();
      for (int b = 0; b < NB; b++) begin
         pool_occ[b]   = '0;
         pool_shots[b] = '0;
         pool_id[b]    = '0;
         pool_frag[b]  = '0;
      end
      cluster_no = '0;
      bundle_sz  = pccb_pkg::BSIZE_RST;
   endtask

   // commit pool b into a result word and empty it
   function automatic rsp_word_type pool_commit(int b, bit resid);
      rsp_word_type r;
      r = '0;
      cluster_no       = cluster_no + 32'd1;
      r.committed      = 1'b1;
      r.residual       = resid;
      r.out_backend    = b[7:0];
      r.cluster_number = cluster_no;
      r.shot_total     = pool_shots[b];
      r.head_id        = pool_id[b];
      r.head_fragment  = resid ? 8'd0 : pool_frag[b];
      r.eta_add_ns     = {10'd0, pool_shots[b]} * {24'd0, pccb_pkg::NS_PER_SHOT};
      pool_occ[b]   = '0;
      pool_shots[b] = '0;
      pool_id[b]    = '0;
      pool_frag[b]  = '0;
      return r;
   endfunction

   // advance the mirror by one accepted word and queue what it should produce;
   // a typed row replaces the computed result with the one written in the table
   task automatic bundle_predict(input req_word_type w, input bit typed,
                                 input rsp_word_type want);
      rsp_word_type r;
      rsp_word_type fl_q [$];
      logic [24:0]  sum;
      int           b;
      r = '0;
      if (w.action == ACT_INTAKE) begin
         r.out_backend = w.backend;
         r.last        = 1'b1;
         if (w.backend >= NB) begin
            r.status = ST_BAD_BACKEND;
         end else begin
            b = int'(w.backend);
            if (pool_occ[b] == 0) begin
               pool_id[b]   = w.job_id;
               pool_frag[b] = w.fragment;
            end
            if (pool_occ[b] < pccb_pkg::OCC_MAX) pool_occ[b] = pool_occ[b] + 5'd1;
            sum = {1'b0, pool_shots[b]} + {5'd0, w.shots};
            pool_shots[b] = (sum > {1'b0, pccb_pkg::SHOT_SUM_MAX}) ? pccb_pkg::SHOT_SUM_MAX
                                                                  : sum[23:0];
            if (pool_occ[b] >= bundle_sz) begin
               r = pool_commit(b, 1'b0);
               r.last = 1'b1;
            end else begin
               r.pool_count = pool_occ[b];
            end
         end
         fl_q.push_back(r);
      end else begin
         for (b = 0; b < NB; b++) begin
            if (pool_occ[b] != 0) fl_q.push_back(pool_commit(b, 1'b1));
         end
         if (fl_q.size() == 0) begin
            r.last = 1'b1;
            fl_q.push_back(r);
         end else begin
            fl_q[fl_q.size()-1].flushed_count = 7'(fl_q.size());
            fl_q[fl_q.size()-1].last          = 1'b1;
         end
      end
      if (typed) cluster_q.push_back(want);
      else foreach (fl_q[i]) cluster_q.push_back(fl_q[i]);
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      $display("[%0t] result %0d: %s", $time, rsp_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cluster_q.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            e = cluster_q.pop_front();
            check_field("status",         64'(rsp_status),         64'(e.status));
            check_field("committed",      64'(rsp_committed),      64'(e.committed));
            check_field("residual",       64'(rsp_residual),       64'(e.residual));
            check_field("out_backend",    64'(rsp_out_backend),    64'(e.out_backend));
            check_field("cluster_number", 64'(rsp_cluster_number), 64'(e.cluster_number));
            check_field("shot_total",     64'(rsp_shot_total),     64'(e.shot_total));
            check_field("head_id",        64'(rsp_head_id),        64'(e.head_id));
            check_field("head_fragment",  64'(rsp_head_fragment),  64'(e.head_fragment));
            check_field("eta_add_ns",     64'(rsp_eta_add_ns),     64'(e.eta_add_ns));
            check_field("pool_count",     64'(rsp_pool_count),     64'(e.pool_count));
            check_field("flushed_count",  64'(rsp_flushed_count),  64'(e.flushed_count));
            check_field("last",           64'(rsp_last),           64'(e.last));
         end
         rsp_seen++;
      end
   end

   // watchdog: too long with no word moving on either channel
   int quiet_cycles;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure, one long hold-off, a calm stretch
   // ---------------------------------------------------------------------
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end else if (rsp_seen >= 90 && rsp_seen < 130) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type want);
      bit calm;
      calm = (rand_items >= 60 && rand_items < 85);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= w.action;
      req_backend  <= w.backend;
      req_job_id   <= w.job_id;
      req_fragment <= w.fragment;
      req_shots    <= w.shots;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bundle_predict(w, typed, want);
   endtask

   // drop valid, let every owed result come back, then wait out the pipeline
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (cluster_q.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic write_bundle_size(input logic [4:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      bundle_sz = v;
   endtask

   function automatic rsp_word_type rsp_hold(logic [7:0] b, logic [4:0] n);
      rsp_word_type r;
      r = '0;
      r.status      = ST_OK;
      r.out_backend = b;
      r.pool_count  = n;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic rsp_word_type rsp_reject(logic [7:0] b);
      rsp_word_type r;
      r = '0;
      r.status      = ST_BAD_BACKEND;
      r.out_backend = b;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic rsp_word_type rsp_empty_flush();
      rsp_word_type r;
      r = '0;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic add_row(bit wr, logic [4:0] sz, logic act, logic [7:0] b, logic [31:0] id,
                          logic [7:0] frag, logic [19:0] sh, bit typed, rsp_word_type want);
      dir_row_type row;
      row.wr_size    = wr;
      row.size       = sz;
      row.w.action   = act;
      row.w.backend  = b;
      row.w.job_id   = id;
      row.w.fragment = frag;
      row.w.shots    = sh;
      row.typed      = typed;
      row.want       = want;
      dir_tab.push_back(row);
   endtask

   // random phases: bundle size (-1 picks one), words, top backend,
   // flush %, full-scale shots %, out-of-range backend %
   int ph_size  [7] = '{31, 16,  1,  0, -1, -1, -1};
   int ph_words [7] = '{36, 16, 10,  8,  9,  9,  9};
   int ph_bhi   [7] = '{ 0,  3,  7,  7,  7,  7,  7};
   int ph_flush [7] = '{ 0,  5,  8,  8, 10, 10, 10};
   int ph_max   [7] = '{80, 10, 10, 10, 10, 10, 10};
   int ph_rej   [7] = '{ 3,  8, 10, 10, 10, 10, 10};

   initial begin
      req_word_type w;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_action   = ACT_INTAKE;
      req_backend  = '0;
      req_job_id   = '0;
      req_fragment = '0;
      req_shots    = '0;
      rsp_ready    = 1'b0;
      mismatches   = 0;
      rsp_seen     = 0;
      rand_items   = 0;
      table_clear();

      // directed table, bundle size 5 out of reset
      add_row(0, 0,  ACT_FLUSH,  8'd0,   32'h0,        8'h00, 20'h0,     1, rsp_empty_flush());
      add_row(0, 0,  ACT_INTAKE, 8'd8,   32'h0,        8'h00, 20'h0,     1, rsp_reject(8'd8));
      add_row(0, 0,  ACT_INTAKE, 8'd255, 32'hFFFFFFFF, 8'hFF, 20'hFFFFF, 1, rsp_reject(8'd255));
      add_row(0, 0,  ACT_INTAKE, 8'd0,   32'hFFFFFFFF, 8'hFF, 20'hFFFFF, 1, rsp_hold(8'd0, 5'd1));
      add_row(0, 0,  ACT_INTAKE, 8'd0,   32'h1,        8'h01, 20'hFFFFF, 1, rsp_hold(8'd0, 5'd2));
      add_row(0, 0,  ACT_INTAKE, 8'd0,   32'h2,        8'h02, 20'hFFFFF, 1, rsp_hold(8'd0, 5'd3));
      add_row(0, 0,  ACT_INTAKE, 8'd0,   32'h3,        8'h03, 20'hFFFFF, 1, rsp_hold(8'd0, 5'd4));
      add_row(0, 0,  ACT_INTAKE, 8'd0,   32'h4,        8'h04, 20'hFFFFF, 0, '0);  // fills pool
      add_row(0, 0,  ACT_INTAKE, 8'd7,   32'h0,        8'h00, 20'h0,     1, rsp_hold(8'd7, 5'd1));
      add_row(0, 0,  ACT_INTAKE, 8'd3,   32'hA5A5A5A5, 8'h5A, 20'h12345, 1, rsp_hold(8'd3, 5'd1));
      add_row(0, 0,  ACT_FLUSH,  8'hFF,  32'hFFFFFFFF, 8'hFF, 20'hFFFFF, 0, '0);  // two residuals
      add_row(0, 0,  ACT_FLUSH,  8'd3,   32'h0,        8'h00, 20'h0,     1, rsp_empty_flush());
      add_row(0, 0,  ACT_INTAKE, 8'd1,   32'h11,       8'h10, 20'h100,   1, rsp_hold(8'd1, 5'd1));
      add_row(0, 0,  ACT_INTAKE, 8'd1,   32'h12,       8'h11, 20'h200,   1, rsp_hold(8'd1, 5'd2));
      add_row(0, 0,  ACT_INTAKE, 8'd1,   32'h13,       8'h12, 20'h300,   1, rsp_hold(8'd1, 5'd3));
      // size lowered under a filling pool: commits on its next word
      add_row(1, 2,  ACT_INTAKE, 8'd1,   32'h14,       8'h13, 20'h400,   0, '0);
      // size 0 behaves as 1
      add_row(1, 0,  ACT_INTAKE, 8'd2,   32'h21,       8'h20, 20'h1,     0, '0);
      add_row(1, 16, ACT_INTAKE, 8'd4,   32'h41,       8'h40, 20'hABCDE, 1, rsp_hold(8'd4, 5'd1));
      add_row(1, 31, ACT_INTAKE, 8'd4,   32'h42,       8'h41, 20'h54321, 1, rsp_hold(8'd4, 5'd2));
      add_row(1, 1,  ACT_INTAKE, 8'd5,   32'h51,       8'h50, 20'h7,     0, '0);
      add_row(0, 0,  ACT_FLUSH,  8'd0,   32'h0,        8'h00, 20'h0,     0, '0);
      add_row(1, 5,  ACT_INTAKE, 8'd6,   32'h61,       8'h60, 20'h9,     1, rsp_hold(8'd6, 5'd1));
      add_row(0, 0,  ACT_FLUSH,  8'd0,   32'h0,        8'h00, 20'h0,     0, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].wr_size) write_bundle_size(dir_tab[i].size);
         send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
      end

      // random phases; the first one piles full-scale shots into one pool at
      // size 31 so the shot sum saturates before the commit
      for (int p = 0; p < 7; p++) begin
         write_bundle_size(ph_size[p] < 0 ? 5'($urandom_range(31, 0)) : 5'(ph_size[p]));
         for (int k = 0; k < ph_words[p]; k++) begin
            w.action   = ($urandom_range(99) < ph_flush[p]) ? ACT_FLUSH : ACT_INTAKE;
            w.backend  = ($urandom_range(99) < ph_rej[p]) ? 8'($urandom_range(255, NB))
                                                           : 8'($urandom_range(ph_bhi[p], 0));
            w.job_id   = $urandom;
            w.fragment = 8'($urandom_range(255, 0));
            w.shots    = ($urandom_range(99) < ph_max[p]) ? 20'hFFFFF
                                                          : 20'($urandom_range(20'hFFFFF, 0));
            send_word(w, 1'b0, '0);
            rand_items++;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && cluster_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
